// File: design/atl_pkg.sv
// Shared types, codes and byte classification for the assembler token lexer.
package atl_pkg;

  typedef enum logic [2:0] {
    KIND_WORD    = 3'd0,
    KIND_KEYWORD = 3'd1,
    KIND_PUNCT   = 3'd2,
    KIND_INT     = 3'd3,
    KIND_REAL    = 3'd4,
    KIND_END     = 3'd5,
    KIND_ERROR   = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNKNOWN   = 2'd1,
    ERR_MALFORMED = 2'd2,
    ERR_TOO_LONG  = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_WORD = 4'b0010,
    MODE_NUM  = 4'b0100,
    MODE_ERR  = 4'b1000
  } mode_e;

  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChLBrk  = 8'h5b;
  localparam logic [7:0] ChRBrk  = 8'h5d;
  localparam logic [7:0] ChLBrc  = 8'h7b;
  localparam logic [7:0] ChRBrc  = 8'h7d;
  localparam logic [7:0] ChLPar  = 8'h28;
  localparam logic [7:0] ChRPar  = 8'h29;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChUnder = 8'h5f;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] CaseBit = 8'h20;
  localparam logic [7:0] LowE    = 8'h65;
  localparam logic [7:0] LowX    = 8'h78;

  // Byte classes, worked out once in the front end.
  typedef struct packed {
    logic space;
    logic punct;
    logic alpha;
    logic digit;
    logic under;
    logic minus;
    logic dot;
    logic zero;
    logic exp;
    logic hexlet;
    logic xmark;
  } cls_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    cls_t       cls;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] start;
    logic [7:0]  length;
    logic [7:0]  punct;
    err_e        err;
    logic        last;
  } token_t;

  function automatic cls_t classify(logic [7:0] c);
    cls_t       r;
    logic [7:0] l;
    l        = c | CaseBit;
    r.space  = (c == ChSpace) || (c >= 8'h09 && c <= 8'h0d);
    r.punct  = (c == ChDot) || (c == ChColon) || (c == ChLBrk) || (c == ChRBrk) ||
               (c == ChLBrc) || (c == ChRBrc) || (c == ChLPar) || (c == ChRPar);
    r.alpha  = (l > 8'h60) && (l < 8'h7b);
    r.digit  = (c > 8'h2f) && (c < 8'h3a);
    r.under  = (c == ChUnder);
    r.minus  = (c == ChMinus);
    r.dot    = (c == ChDot);
    r.zero   = (c == ChZero);
    r.exp    = (l == LowE);
    r.hexlet = (l > 8'h60) && (l < 8'h67);
    r.xmark  = (l == LowX);
    return r;
  endfunction

  // Letters of the one keyword, "halt".
  function automatic logic [7:0] kw_char(logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = 8'h68;
      2'd1: r = 8'h61;
      2'd2: r = 8'h6c;
      2'd3: r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: design/atl_if.sv
// Handshake channels of the lexer: source bytes in, tokens out.
interface atl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_flag;

  modport source (output valid, output data_byte, output end_flag, input ready);
  modport sink (input valid, input data_byte, input end_flag, output ready);
endinterface

interface atl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [31:0] token_start;
  logic [7:0]  token_length;
  logic [7:0]  punct_char;
  logic [1:0]  error_code;
  logic        run_last;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output punct_char, output error_code, output run_last, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_length,
                input punct_char, input error_code, input run_last, output ready);
endinterface

// File: design/atl_front.sv
// Front end: takes source beats, classifies each byte, queues it for the lexer core.
module atl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [7:0]      data_byte_i,
  input  logic            end_flag_i,
  output logic            ent_valid_o,
  input  logic            ent_ready_i,
  output atl_pkg::entry_t ent_o
);
  import atl_pkg::*;

  entry_t     mem_q [2];
  logic       head_q, head_d;
  logic       tail_q, tail_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign ready_o     = (cnt_q != 2'd2);
  assign ent_valid_o = (cnt_q != 2'd0);
  assign ent_o       = mem_q[head_q];
  assign push        = valid_i && ready_o;
  assign pop         = ent_valid_o && ent_ready_i;

  always_comb begin
    head_d = pop ? ~head_q : head_q;
    tail_d = push ? ~tail_q : tail_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 1'b0;
      tail_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[tail_q] <= '{data: data_byte_i, last: end_flag_i, cls: classify(data_byte_i)};
    end
  end

endmodule

// File: design/atl_back.sv
// Lexer core: token state machine plus a four-deep result queue.
module atl_back #(
  parameter int LenLimit = 255
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            ent_valid_i,
  output logic            ent_ready_o,
  input  atl_pkg::entry_t ent_i,
  output logic            tok_valid_o,
  input  logic            tok_ready_i,
  output atl_pkg::token_t tok_o
);
  import atl_pkg::*;

  localparam logic [7:0] LimitW = 8'(LenLimit);

  // token state
  mode_e       mode_q, mode_d;
  logic [7:0]  len_q, len_d;
  logic        hex_q, hex_d;
  logic        real_q, real_d;
  logic        lz_q, lz_d;
  logic [2:0]  kwp_q, kwp_d;
  logic        kwm_q, kwm_d;
  logic [31:0] start_q, start_d;
  logic [31:0] off_q, off_d;

  // result queue
  token_t      res_q [4];
  logic [1:0]  head_q, tail_q;
  logic [2:0]  cnt_q;
  logic        pop;
  logic [1:0]  push_n;

  logic        step;
  logic [7:0]  c;
  cls_t        cls;
  token_t      flush_res, beg_res, a_res, b_res;
  logic        beg_v, a_v, b_v, do_begin, did_flush;
  logic        beg_open;
  mode_e       beg_mode;
  logic        word_cont, num_cont, hexmark;

  assign step = ent_valid_i && ent_ready_o;
  assign c    = ent_i.data;
  assign cls  = ent_i.cls;

  always_comb begin
    flush_res        = '0;
    flush_res.kind   = (mode_q == MODE_WORD) ?
                       ((!kwm_q && kwp_q == 3'd4) ? KIND_KEYWORD : KIND_WORD) :
                       (real_q ? KIND_REAL : KIND_INT);
    flush_res.start  = start_q;
    flush_res.length = len_q;
    flush_res.err    = ERR_NONE;
  end

  // What a byte does when it opens a new token.
  always_comb begin
    beg_res  = '0;
    beg_v    = 1'b0;
    beg_open = 1'b0;
    beg_mode = MODE_IDLE;
    if (cls.space) begin
      beg_mode = MODE_IDLE;
    end else if (cls.punct) begin
      beg_v          = 1'b1;
      beg_res.kind   = KIND_PUNCT;
      beg_res.start  = off_q;
      beg_res.length = 8'd1;
      beg_res.punct  = c;
      beg_res.err    = ERR_NONE;
    end else begin
      beg_open = 1'b1;
      if (cls.alpha || cls.under) begin
        beg_mode = MODE_WORD;
      end else if (cls.digit || cls.minus) begin
        beg_mode = MODE_NUM;
      end else begin
        beg_mode      = MODE_ERR;
        beg_v         = 1'b1;
        beg_res.kind  = KIND_ERROR;
        beg_res.start = off_q;
        beg_res.err   = ERR_UNKNOWN;
      end
    end
  end

  assign word_cont = cls.alpha || cls.digit || cls.under;
  assign hexmark   = lz_q && (len_q == 8'd1) && cls.xmark;
  assign num_cont  = hexmark || cls.digit || cls.dot || cls.exp || (hex_q && cls.hexlet);

  always_comb begin
    mode_d    = mode_q;
    len_d     = len_q;
    hex_d     = hex_q;
    real_d    = real_q;
    lz_d      = lz_q;
    kwp_d     = kwp_q;
    kwm_d     = kwm_q;
    start_d   = start_q;
    off_d     = off_q;
    a_res     = '0;
    b_res     = '0;
    a_v       = 1'b0;
    b_v       = 1'b0;
    do_begin  = 1'b0;
    did_flush = 1'b0;
    if (step) begin
      if (ent_i.last) begin
        if (mode_q == MODE_WORD || mode_q == MODE_NUM) begin
          a_v         = 1'b1;
          a_res       = flush_res;
          b_v         = 1'b1;
          b_res.kind  = KIND_END;
          b_res.start = off_q;
          b_res.err   = ERR_NONE;
        end else begin
          a_v         = 1'b1;
          a_res.kind  = KIND_END;
          a_res.start = off_q;
          a_res.err   = ERR_NONE;
        end
        mode_d  = MODE_IDLE;
        len_d   = 8'd0;
        hex_d   = 1'b0;
        real_d  = 1'b0;
        lz_d    = 1'b0;
        kwp_d   = 3'd0;
        kwm_d   = 1'b0;
        start_d = 32'd0;
        off_d   = 32'd0;
      end else begin
        off_d = off_q + 32'd1;
        unique case (mode_q)
          MODE_IDLE: do_begin = 1'b1;
          MODE_WORD: begin
            if (word_cont) begin
              if (len_q >= LimitW) begin
                a_v         = 1'b1;
                a_res.kind  = KIND_ERROR;
                a_res.start = start_q;
                a_res.err   = ERR_TOO_LONG;
                mode_d      = MODE_ERR;
              end else begin
                if (!kwm_q && len_q < 8'd4 && kwp_q == len_q[2:0] &&
                    c == kw_char(len_q[1:0])) begin
                  kwp_d = kwp_q + 3'd1;
                end else begin
                  kwm_d = 1'b1;
                end
                len_d = len_q + 8'd1;
              end
            end else begin
              did_flush = 1'b1;
              do_begin  = 1'b1;
            end
          end
          MODE_NUM: begin
            if (num_cont) begin
              if (len_q >= LimitW) begin
                a_v         = 1'b1;
                a_res.kind  = KIND_ERROR;
                a_res.start = start_q;
                a_res.err   = ERR_TOO_LONG;
                mode_d      = MODE_ERR;
              end else if (!hexmark && cls.dot && (real_q || hex_q)) begin
                a_v         = 1'b1;
                a_res.kind  = KIND_ERROR;
                a_res.start = start_q;
                a_res.err   = ERR_MALFORMED;
                mode_d      = MODE_ERR;
              end else begin
                if (hexmark) hex_d = 1'b1;
                if (!hexmark && cls.dot) real_d = 1'b1;
                len_d = len_q + 8'd1;
              end
            end else begin
              did_flush = 1'b1;
              do_begin  = 1'b1;
            end
          end
          MODE_ERR: ;
          default: ;
        endcase

        if (do_begin) begin
          mode_d = beg_mode;
          if (beg_open) begin
            start_d = off_q;
            hex_d   = 1'b0;
            real_d  = 1'b0;
            lz_d    = (beg_mode == MODE_NUM) && cls.zero;
            len_d   = (beg_mode == MODE_ERR) ? 8'd0 : 8'd1;
            kwp_d   = 3'd0;
            kwm_d   = 1'b0;
            if (beg_mode == MODE_WORD) begin
              if (c == kw_char(2'd0)) kwp_d = 3'd1;
              else kwm_d = 1'b1;
            end
          end
          if (did_flush) begin
            a_v   = 1'b1;
            a_res = flush_res;
            b_v   = beg_v;
            b_res = beg_res;
          end else begin
            a_v   = beg_v;
            a_res = beg_res;
          end
        end
      end
    end
    if (b_v) b_res.last = 1'b1;
    else a_res.last = 1'b1;
  end

  // Room for two results keeps the core from stalling mid-byte.
  assign ent_ready_o = (cnt_q <= 3'd2);
  assign tok_valid_o = (cnt_q != 3'd0);
  assign tok_o       = res_q[head_q];
  assign pop         = tok_valid_o && tok_ready_i;
  assign push_n      = {1'b0, a_v} + {1'b0, b_v};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      len_q   <= 8'd0;
      hex_q   <= 1'b0;
      real_q  <= 1'b0;
      lz_q    <= 1'b0;
      kwp_q   <= 3'd0;
      kwm_q   <= 1'b0;
      start_q <= 32'd0;
      off_q   <= 32'd0;
      head_q  <= 2'd0;
      tail_q  <= 2'd0;
      cnt_q   <= 3'd0;
    end else begin
      mode_q  <= mode_d;
      len_q   <= len_d;
      hex_q   <= hex_d;
      real_q  <= real_d;
      lz_q    <= lz_d;
      kwp_q   <= kwp_d;
      kwm_q   <= kwm_d;
      start_q <= start_d;
      off_q   <= off_d;
      head_q  <= head_q + 2'(pop);
      tail_q  <= tail_q + push_n;
      cnt_q   <= cnt_q + 3'(push_n) - 3'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_v) res_q[tail_q] <= a_res;
    if (b_v) res_q[tail_q + 2'd1] <= b_res;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result queue overflow");

  a_err_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !ent_i.last && mode_q == MODE_ERR) |-> (push_n == 2'd0))
    else $error("result produced while dropping bytes after an error");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && ent_i.last) |=> (mode_q == MODE_IDLE && off_q == 32'd0))
    else $error("state not cleared after end of input");
`endif

endmodule

// File: design/assembler_token_lexer_core.sv
// Top level of the assembler token lexer: front end, lexer core, token channel.
//
// src_i carries one source byte per beat (data_byte, end_flag); a beat is taken
// when valid and ready are both high. tok_o carries one token per beat: kind,
// start offset, length, punctuation byte, error code and run_last, which marks
// the last token caused by an input beat. A byte gives zero, one or two tokens.
//
// Throughput: one byte per cycle while the receiver keeps up, handled by the token
// state machine in the core. A byte that gives two tokens writes both into the
// result queue together. A taken byte is registered in the classify queue; the core
// reads it from there and writes its tokens straight into the result queue, which
// drives tok_o. A second token from the same byte leaves behind the first.
//
// The front queue (two entries) and the result queue (four entries) let either
// side stall on its own. When the receiver stalls, the result queue fills and the
// core stops taking bytes once fewer than two slots are free; the front queue
// then fills and src_i.ready drops. No token is lost or repeated.
//
// Reset (rst_ni low, asynchronous) empties both queues, returns the lexer to
// idle and zeroes the byte offset. An end_flag beat flushes the open token, then
// returns the lexer to idle and zeroes the byte offset.
module assembler_token_lexer_core #(
  parameter int MAX_TOKEN_LEN = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  atl_in_if.sink    src_i,
  atl_out_if.source tok_o
);
  import atl_pkg::*;

  // Longest token in bytes; token_length is eight bits wide.
  localparam int LenLimit = (MAX_TOKEN_LEN - 1 > 255) ? 255 : MAX_TOKEN_LEN - 1;

  entry_t ent;
  logic   ent_valid, ent_ready;
  token_t tok;

  atl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (src_i.valid),
    .ready_o     (src_i.ready),
    .data_byte_i (src_i.data_byte),
    .end_flag_i  (src_i.end_flag),
    .ent_valid_o (ent_valid),
    .ent_ready_i (ent_ready),
    .ent_o       (ent)
  );

  atl_back #(
    .LenLimit (LenLimit)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (ent_valid),
    .ent_ready_o (ent_ready),
    .ent_i       (ent),
    .tok_valid_o (tok_o.valid),
    .tok_ready_i (tok_o.ready),
    .tok_o       (tok)
  );

  assign tok_o.token_kind   = tok.kind;
  assign tok_o.token_start  = tok.start;
  assign tok_o.token_length = tok.length;
  assign tok_o.punct_char   = tok.punct;
  assign tok_o.error_code   = tok.err;
  assign tok_o.run_last     = tok.last;

endmodule
